### hw/rtl/rdce_pkg.sv
// Shared types and constants for the doubled-symbol run-length encoder.
`default_nettype none

package rdce_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // Header of one closed run waiting to be serialized.
  typedef struct packed {
    logic [7:0] sym;
    logic       single;   // run of length one: symbol only
    logic       last;     // final byte of this run closes the input word
  } run_hdr_t;

  // What a decimal counter cell reports to the encoder and to its neighbor.
  typedef struct packed {
    logic [3:0] cur;
    logic [3:0] bumped;
    logic       carry;
    logic       nine;
  } cell_stat_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef enum logic [1:0] {
    PH_SYM0,
    PH_SYM1,
    PH_DIGIT
  } phase_t;

  localparam logic [3:0] DIGIT_MAX      = 4'd9;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
  localparam int         QUEUE_DEPTH    = 3;
  localparam int         CNT_W          = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

### hw/rtl/rdce_digit_cell.sv
// One decimal digit of the run count, with carry to the next higher digit.
`default_nettype none

module rdce_digit_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   clr,
  input  logic                   inc,
  output rdce_pkg::cell_stat_t   stat
);
  import rdce_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;

  always_comb begin
    stat.cur    = digit_r;
    stat.nine   = (digit_r == DIGIT_MAX);
    stat.carry  = inc && stat.nine;
    stat.bumped = inc ? (stat.nine ? 4'd0 : digit_r + 4'd1) : digit_r;
    digit_nxt   = clr ? 4'd0 : stat.bumped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 4'd0;
    end else if (en) begin
      digit_r <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rdce_emitter.sv
// Queue of closed runs and the serializer that turns each into output bytes.
`default_nettype none

module rdce_emitter #(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rdce_pkg::push_t                    push,
  input  rdce_pkg::run_hdr_t                 hdr0,
  input  rdce_pkg::run_hdr_t                 hdr1,
  input  logic [COUNT_DIGITS-1:0][3:0]       dig0,
  input  logic [COUNT_DIGITS-1:0][3:0]       dig1,
  output logic                               room,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rdce_pkg::out_word_t                out_data
);
  import rdce_pkg::*;

  localparam int DIG_IW = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  run_hdr_t                     hdr_r   [QUEUE_DEPTH];
  run_hdr_t                     hdr_nxt [QUEUE_DEPTH];
  run_hdr_t                     hdr_sh  [QUEUE_DEPTH];
  logic [COUNT_DIGITS-1:0][3:0] dig_r   [QUEUE_DEPTH];
  logic [COUNT_DIGITS-1:0][3:0] dig_nxt [QUEUE_DEPTH];
  logic [COUNT_DIGITS-1:0][3:0] dig_sh  [QUEUE_DEPTH];
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;
  logic [CNT_W-1:0]             wr0;
  logic [CNT_W-1:0]             wr1;
  phase_t                       phase_r;
  phase_t                       phase_nxt;
  logic [DIG_IW-1:0]            pos_r;
  logic [DIG_IW-1:0]            pos_nxt;
  logic                         fire;
  logic                         pop;
  logic                         last_byte;
  logic [7:0]                   byte_out;

  function automatic logic [DIG_IW-1:0] msd_of(input logic [COUNT_DIGITS-1:0][3:0] d);
    logic [DIG_IW-1:0] m;
    m = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (d[i] != 4'd0) m = DIG_IW'(i);
    end
    return m;
  endfunction

  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign fire      = out_valid && out_ready;
  assign pop       = fire && last_byte;

  // Output selection for the current phase of the head run.
  always_comb begin
    unique case (phase_r)
      PH_SYM0: begin
        byte_out  = hdr_r[0].sym;
        last_byte = hdr_r[0].single;
      end
      PH_SYM1: begin
        byte_out  = hdr_r[0].sym;
        last_byte = 1'b0;
      end
      PH_DIGIT: begin
        byte_out  = {ASCII_DIGIT_HI, dig_r[0][pos_r]};
        last_byte = (pos_r == '0);
      end
      default: begin
        byte_out  = hdr_r[0].sym;
        last_byte = 1'b0;
      end
    endcase
    out_data.out_byte = byte_out;
    out_data.out_last = last_byte && hdr_r[0].last;
  end

  // Phase sequencing: symbol; for a longer run, symbol again, then digits from the most significant.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (fire) begin
      unique case (phase_r)
        PH_SYM0: begin
          if (!hdr_r[0].single) phase_nxt = PH_SYM1;
        end
        PH_SYM1: begin
          phase_nxt = PH_DIGIT;
          pos_nxt   = msd_of(dig_r[0]);
        end
        PH_DIGIT: begin
          if (pos_r == '0) begin
            phase_nxt = PH_SYM0;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
        default: phase_nxt = PH_SYM0;
      endcase
    end
  end

  // Queue: drop the head on pop, then append up to two runs behind the rest.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      hdr_sh[i] = hdr_r[i + 1];
      dig_sh[i] = dig_r[i + 1];
    end
    hdr_sh[QUEUE_DEPTH-1] = hdr_r[QUEUE_DEPTH-1];
    dig_sh[QUEUE_DEPTH-1] = dig_r[QUEUE_DEPTH-1];

    wr0     = cnt_r - CNT_W'(pop);
    wr1     = wr0 + 1'b1;
    cnt_nxt = wr0 + CNT_W'(push.push0) + CNT_W'(push.push1);

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hdr_nxt[i] = pop ? hdr_sh[i] : hdr_r[i];
      dig_nxt[i] = pop ? dig_sh[i] : dig_r[i];
      if (push.push0 && (CNT_W'(i) == wr0)) begin
        hdr_nxt[i] = hdr0;
        dig_nxt[i] = dig0;
      end
      if (push.push1 && (CNT_W'(i) == wr1)) begin
        hdr_nxt[i] = hdr1;
        dig_nxt[i] = dig1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hdr_r[i] <= hdr_nxt[i];
      dig_r[i] <= dig_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= PH_SYM0;
      pos_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rle_doubled_char_decimal_encoder.sv
// Top level: run tracking, decimal counter chain and the output serializer.
//
//   channel  direction  handshake               word
//   in       input      in_valid / in_ready     in_data  (in_byte, in_last)
//   out      output     out_valid / out_ready   out_data (out_byte, out_last)
//
// One input word is taken per cycle while at most one closed run waits in the
// three-entry run queue; bytes leave at one per cycle from the queue head while
// out_ready is high. A single run gives 1 byte, others 3 to 2 + COUNT_DIGITS.
// The run count is held in a chain of decimal digit cells, so no conversion
// is needed. rst_n (synchronous) clears the run state, counter and queue.
// out_ready low holds the head byte; in_ready drops once two runs are queued.
`default_nettype none

module rle_doubled_char_decimal_encoder #(
  parameter int unsigned MAX_RUN      = 65535,
  parameter int          COUNT_DIGITS = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rdce_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rdce_pkg::out_word_t  out_data
);
  import rdce_pkg::*;

  localparam int             LEN_W   = $clog2(64'(MAX_RUN) + 64'd1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RUN);

  logic [7:0]                   sym_r;
  logic [7:0]                   sym_nxt;
  logic [LEN_W-1:0]             len_r;
  logic [LEN_W-1:0]             len_nxt;
  logic [LEN_W-1:0]             len_ext;
  logic                         open_r;
  logic                         open_nxt;
  logic                         accept;
  logic                         hit;
  logic                         close_ext;
  logic                         all_nine;
  logic                         inc0;
  logic                         cell_clr;
  logic                         room;
  cell_stat_t                   stat  [COUNT_DIGITS];
  logic [COUNT_DIGITS-1:0]      carry_in;
  logic [COUNT_DIGITS-1:0]      nines;
  logic [COUNT_DIGITS-1:0][3:0] cur_digits;
  logic [COUNT_DIGITS-1:0][3:0] bumped_digits;
  push_t                        push;
  run_hdr_t                     hdr0;
  run_hdr_t                     hdr1;
  run_hdr_t                     hdr_single;
  logic [COUNT_DIGITS-1:0][3:0] dig0;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  assign hit       = open_r && (in_data.in_byte == sym_r) && (len_r < MAX_LEN);
  assign len_ext   = len_r + 1'b1;
  assign close_ext = hit && ((len_ext == MAX_LEN) || in_data.in_last);

  // Count holds length minus two; hold it at all nines once saturated.
  assign all_nine = &nines;
  assign inc0     = accept && hit && (len_r != LEN_W'(1)) && !all_nine;
  assign cell_clr = !hit || close_ext;

  for (genvar g = 0; g < COUNT_DIGITS; g++) begin : g_cell
    if (g == 0) begin : g_lsd
      assign carry_in[g] = inc0;
    end else begin : g_upper
      assign carry_in[g] = stat[g-1].carry;
    end

    rdce_digit_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (accept),
      .clr   (cell_clr),
      .inc   (carry_in[g]),
      .stat  (stat[g])
    );

    assign nines[g]         = stat[g].nine;
    assign cur_digits[g]    = stat[g].cur;
    assign bumped_digits[g] = stat[g].bumped;
  end

  // Closed runs of a word: old run, then a one-byte run flushed on a final word;
  // a lone final byte; or a continued run closed by the length limit or final byte.
  always_comb begin
    hdr_single.sym    = in_data.in_byte;
    hdr_single.single = 1'b1;
    hdr_single.last   = 1'b1;
    hdr1              = hdr_single;
    push.push1        = 1'b0;
    if (hit) begin
      push.push0  = accept && close_ext;
      hdr0.sym    = sym_r;
      hdr0.single = 1'b0;
      hdr0.last   = 1'b1;
      dig0        = bumped_digits;
    end else if (open_r) begin
      push.push0  = accept;
      push.push1  = accept && in_data.in_last;
      hdr0.sym    = sym_r;
      hdr0.single = (len_r == LEN_W'(1));
      hdr0.last   = !in_data.in_last;
      dig0        = cur_digits;
    end else begin
      push.push0  = accept && in_data.in_last;
      hdr0        = hdr_single;
      dig0        = '0;
    end
  end

  always_comb begin
    sym_nxt = hit ? sym_r : in_data.in_byte;
    if (hit) begin
      len_nxt  = close_ext ? '0 : len_ext;
      open_nxt = !close_ext;
    end else begin
      len_nxt  = in_data.in_last ? '0 : LEN_W'(1);
      open_nxt = !in_data.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r  <= 8'd0;
      len_r  <= '0;
      open_r <= 1'b0;
    end else if (accept) begin
      sym_r  <= sym_nxt;
      len_r  <= len_nxt;
      open_r <= open_nxt;
    end
  end

  rdce_emitter #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .hdr0      (hdr0),
    .hdr1      (hdr1),
    .dig0      (dig0),
    .dig1      ('0),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/tb_rle_doubled_char_decimal_encoder.sv
// Testbench for the run-length encoder: directed and random texts against a predictor.
module tb_rle_doubled_char_decimal_encoder;

  import rdce_pkg::*;

  localparam int unsigned MAX_RUN      = 65535;
  localparam int          COUNT_DIGITS = 5;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam int          RANDOM_ITEMS = 220;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_TAIL   = 64;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_COIN,
    RX_TIDE
  } rx_mode_t;

  // Tracks the open run and holds the encoded bytes still owed by the block.
  class encoded_stream_model;
    logic [7:0]  run_sym;
    int unsigned run_len;
    bit          run_open;
    logic [7:0]  spelled[$];
    out_word_t   pending_bytes[$];
    int          mismatches;

    function new();
      run_sym    = 8'h00;
      run_len    = 0;
      run_open   = 1'b0;
      mismatches = 0;
    endfunction

    function void spell_run();
      longint unsigned count;
      longint unsigned cap;
      logic [7:0]      digs[$];
      if (run_len == 0) return;
      spelled.push_back(run_sym);
      if (run_len == 1) return;
      spelled.push_back(run_sym);
      cap = 1;
      repeat (COUNT_DIGITS) cap = cap * 10;
      cap   = cap - 1;
      count = longint'(run_len) - 2;
      if (count > cap) count = cap;
      do begin
        digs.push_front(ASCII_ZERO + 8'(count % 10));
        count = count / 10;
      end while (count != 0);
      foreach (digs[i]) spelled.push_back(digs[i]);
    endfunction

    function void absorb_byte(in_word_t w);
      out_word_t o;
      spelled = {};
      if (run_open && w.in_byte == run_sym && run_len < MAX_RUN) begin
        run_len++;
      end else begin
        if (run_open) spell_run();
        run_sym  = w.in_byte;
        run_len  = 1;
        run_open = 1'b1;
      end
      if (run_len >= MAX_RUN || w.in_last) begin
        spell_run();
        run_len  = 0;
        run_open = 1'b0;
      end
      foreach (spelled[i]) begin
        o.out_byte = spelled[i];
        o.out_last = (i == spelled.size() - 1);
        pending_bytes.push_back(o);
      end
    endfunction

    function void match_byte(out_word_t got);
      out_word_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got byte %02h last %0b",
                 $time, got.out_byte, got.out_last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, got.out_byte);
      end
      if (got.out_last !== want.out_last) begin
        mismatches++;
        $display("%0t: out_last expected %0b got %0b", $time, want.out_last, got.out_last);
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  encoded_stream_model board = new();

  int       burst_left = 0;
  int       idle_cycles = 0;
  int       rx_hold = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  rle_doubled_char_decimal_encoder #(
    .MAX_RUN      (MAX_RUN),
    .COUNT_DIGITS (COUNT_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offer one word; open a new burst after a random gap when the old one is used up.
  task automatic send_word(input logic [7:0] b, input logic l);
    in_word_t w;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    w.in_byte = b;
    w.in_last = l;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.absorb_byte(w);
  endtask

  task automatic send_run(input logic [7:0] b, input int len, input logic close_text);
    for (int i = 0; i < len; i++) send_word(b, close_text && (i == len - 1));
  endtask

  // Hold the sender until every owed byte has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic send_example_text();
    string text;
    text = "BBssssscgggflpaaaaaa";
    for (int i = 0; i < text.len(); i++) send_word(text[i], i == text.len() - 1);
  endtask

  task automatic send_random_text(output int sent);
    int         runs;
    int         len;
    int         pick;
    logic [7:0] b;
    sent = 0;
    if ($urandom_range(0, 4) == 0) begin
      // noise: loose bytes with scattered text ends
      runs = $urandom_range(1, 10);
      repeat (runs) begin
        send_word(8'($urandom()), $urandom_range(0, 3) == 0);
        sent++;
      end
    end else begin
      runs = $urandom_range(1, 8);
      b = 8'($urandom());
      for (int r = 0; r < runs; r++) begin
        if ($urandom_range(0, 3) != 0) b = 8'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 4);
        else if (pick < 96) len = $urandom_range(5, 14);
        else len = $urandom_range(15, 120);
        send_run(b, len, r == runs - 1);
        sent += len;
      end
    end
  endtask

  // Receiver stalls, result checks and the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.match_byte(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_hold = $urandom_range(20, 200);
    end
    rx_hold--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ((rx_tick / 7) % 2 == 0);
    endcase
  end

  initial begin
    int sent_random;
    int sent;
    sent_random = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, a text end followed by an equal byte, and the worked example
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b1);
    send_example_text();
    drain_results();

    // long run with a three-digit count
    send_run(8'h6D, 102, 1'b1);
    drain_results();

    while (sent_random < RANDOM_ITEMS) begin
      send_random_text(sent);
      sent_random += sent;
      if (sent_random >= RANDOM_ITEMS / 2 && sent_random - sent < RANDOM_ITEMS / 2)
        drain_results();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
